@@ rtl/core/resistor_ladder_key_decoder_assert.svh @@
// Assertion macros for the resistor ladder key decoder
`ifndef RESISTOR_LADDER_KEY_DECODER_ASSERT_SVH
`define RESISTOR_LADDER_KEY_DECODER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define RLKD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define RLKD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/rlkd_pkg.sv @@
// Package: types, constants and register map of the ladder key decoder
`timescale 1ns / 1ps

package rlkd_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int TIME_BITS   = 32;
    localparam int HELD_BITS   = 7;
    localparam int KEY_BITS    = 3;
    localparam int POWER_BIT   = 6;
    localparam int DATA_BITS   = 32;
    localparam int ADDR_BITS   = 5;
    localparam int IDX_BITS    = 3;

    localparam logic [SAMPLE_BITS-1:0] L1_TOP_RST     = SAMPLE_BITS'(3900);
    localparam logic [SAMPLE_BITS-1:0] L1_BACK_RST    = SAMPLE_BITS'(3100);
    localparam logic [SAMPLE_BITS-1:0] L1_CONFIRM_RST = SAMPLE_BITS'(2090);
    localparam logic [SAMPLE_BITS-1:0] L1_LEFT_RST    = SAMPLE_BITS'(750);
    localparam logic [SAMPLE_BITS-1:0] L2_TOP_RST     = SAMPLE_BITS'(1120 + 2780);
    localparam logic [SAMPLE_BITS-1:0] L2_UP_RST      = SAMPLE_BITS'(1120);
    localparam logic [TIME_BITS-1:0]   HOLD_RST       = '0;

    localparam logic [KEY_BITS-1:0] KEY_NONE = 3'd0;

    typedef enum logic [IDX_BITS-1:0] {
        REG_L1_TOP     = 3'd0,
        REG_L1_BACK    = 3'd1,
        REG_L1_CONFIRM = 3'd2,
        REG_L1_LEFT    = 3'd3,
        REG_L2_TOP     = 3'd4,
        REG_L2_UP      = 3'd5,
        REG_HOLD_MS    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] ladder1_top;
        logic [SAMPLE_BITS-1:0] ladder1_back_low;
        logic [SAMPLE_BITS-1:0] ladder1_confirm_low;
        logic [SAMPLE_BITS-1:0] ladder1_left_low;
        logic [SAMPLE_BITS-1:0] ladder2_top;
        logic [SAMPLE_BITS-1:0] ladder2_up_low;
        logic [TIME_BITS-1:0]   hold_ms;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] ladder1_sample;
        logic [SAMPLE_BITS-1:0] ladder2_sample;
        logic                   power_pressed;
        logic [TIME_BITS-1:0]   now_ms;
    } t_in_item;

    typedef struct packed {
        logic [KEY_BITS-1:0]  new_key;
        logic [HELD_BITS-1:0] held_keys;
        logic                 power_long_held;
    } t_out_item;

    typedef struct packed {
        logic                 active;
        logic [TIME_BITS-1:0] start;
    } t_pwr_state;

endpackage

@@ rtl/core/rlkd_regs.sv @@
// Configuration register file with APB-style access
`timescale 1ns / 1ps

module rlkd_regs import rlkd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output t_cfg                 o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_BITS-1:2]);
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_L1_TOP:     n_cfg.ladder1_top         = pwdata[SAMPLE_BITS-1:0];
                REG_L1_BACK:    n_cfg.ladder1_back_low    = pwdata[SAMPLE_BITS-1:0];
                REG_L1_CONFIRM: n_cfg.ladder1_confirm_low = pwdata[SAMPLE_BITS-1:0];
                REG_L1_LEFT:    n_cfg.ladder1_left_low    = pwdata[SAMPLE_BITS-1:0];
                REG_L2_TOP:     n_cfg.ladder2_top         = pwdata[SAMPLE_BITS-1:0];
                REG_L2_UP:      n_cfg.ladder2_up_low      = pwdata[SAMPLE_BITS-1:0];
                REG_HOLD_MS:    n_cfg.hold_ms             = pwdata[TIME_BITS-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_L1_TOP:     prdata = DATA_BITS'(r_cfg.ladder1_top);
            REG_L1_BACK:    prdata = DATA_BITS'(r_cfg.ladder1_back_low);
            REG_L1_CONFIRM: prdata = DATA_BITS'(r_cfg.ladder1_confirm_low);
            REG_L1_LEFT:    prdata = DATA_BITS'(r_cfg.ladder1_left_low);
            REG_L2_TOP:     prdata = DATA_BITS'(r_cfg.ladder2_top);
            REG_L2_UP:      prdata = DATA_BITS'(r_cfg.ladder2_up_low);
            REG_HOLD_MS:    prdata = DATA_BITS'(r_cfg.hold_ms);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ladder1_top         <= L1_TOP_RST;
            r_cfg.ladder1_back_low    <= L1_BACK_RST;
            r_cfg.ladder1_confirm_low <= L1_CONFIRM_RST;
            r_cfg.ladder1_left_low    <= L1_LEFT_RST;
            r_cfg.ladder2_top         <= L2_TOP_RST;
            r_cfg.ladder2_up_low      <= L2_UP_RST;
            r_cfg.hold_ms             <= HOLD_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ rtl/core/rlkd_decode.sv @@
// Bucket compares, new-key priority encode and power hold timing
`timescale 1ns / 1ps

module rlkd_decode import rlkd_pkg::*; (
    input  t_cfg                 i_cfg,
    input  t_in_item             i_item,
    input  logic [HELD_BITS-1:0] i_prev_mask,
    input  t_pwr_state           i_pwr,
    output t_out_item            o_res,
    output t_pwr_state           o_pwr
);

    logic                 w_back;
    logic                 w_confirm;
    logic                 w_left;
    logic                 w_right;
    logic                 w_up;
    logic                 w_down;
    logic [HELD_BITS-1:0] w_mask;
    logic [HELD_BITS-1:0] w_fresh;
    logic [KEY_BITS-1:0]  w_code;
    logic [TIME_BITS-1:0] w_elapsed;
    logic [SAMPLE_BITS-1:0] w_v1;
    logic [SAMPLE_BITS-1:0] w_v2;

    assign w_v1 = i_item.ladder1_sample;
    assign w_v2 = i_item.ladder2_sample;

    // first matching bucket wins
    assign w_back    = (w_v1 <= i_cfg.ladder1_top) && (w_v1 > i_cfg.ladder1_back_low);
    assign w_confirm = !w_back && (w_v1 <= i_cfg.ladder1_back_low)
                       && (w_v1 > i_cfg.ladder1_confirm_low);
    assign w_left    = !w_back && !w_confirm && (w_v1 <= i_cfg.ladder1_confirm_low)
                       && (w_v1 > i_cfg.ladder1_left_low);
    assign w_right   = !w_back && !w_confirm && !w_left && (w_v1 <= i_cfg.ladder1_left_low);
    assign w_up      = (w_v2 <= i_cfg.ladder2_top) && (w_v2 > i_cfg.ladder2_up_low);
    assign w_down    = !w_up && (w_v2 <= i_cfg.ladder2_up_low);

    assign w_mask  = {i_item.power_pressed, w_down, w_up, w_right, w_left, w_confirm, w_back};
    assign w_fresh = w_mask & ~i_prev_mask;

    always_comb begin
        w_code = KEY_NONE;
        for (int k = HELD_BITS - 1; k >= 0; k--) begin
            if (w_fresh[k]) begin
                w_code = KEY_BITS'(k + 1);
            end
        end
    end

    always_comb begin
        o_pwr.active = i_item.power_pressed;
        if (!i_item.power_pressed) begin
            o_pwr.start = '0;
        end else if (i_pwr.active) begin
            o_pwr.start = i_pwr.start;
        end else begin
            o_pwr.start = i_item.now_ms;
        end
    end

    assign w_elapsed = i_item.now_ms - o_pwr.start;

    assign o_res.new_key         = w_code;
    assign o_res.held_keys       = w_mask;
    assign o_res.power_long_held = o_pwr.active && (w_elapsed >= i_cfg.hold_ms);

endmodule

@@ rtl/core/resistor_ladder_key_decoder.sv @@
// Top level: resistor ladder key decoder with input and result registers
//
// Input channel: i_in_valid / o_in_ready carry one poll item (both ladder
// samples, power level, millisecond time). Output channel: o_out_valid /
// i_out_ready carry one result item per poll (new key code, held mask,
// power long-hold flag), in poll order.
// An item taken is held in the input register, decoded combinationally and
// moved into the result register, which drives o_out_valid, once that one
// is empty or being taken. Throughput: one item per cycle unless the
// receiver stalls; the decode is a single pass of compares, a priority
// encode and one 32-bit subtract-compare between two registers. While the
// receiver stalls, the result register holds and the input
// register can still take one more item; o_in_ready drops only when both
// are full. Key and power-hold state advance as an item moves into the
// result register.
// Configuration is through the APB-style port; pready is always high.
// Reset (synchronous, i_rst_n low) empties both registers, clears the
// previous key mask and the power-hold timer and loads the default bounds.
`timescale 1ns / 1ps

module resistor_ladder_key_decoder import rlkd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

`include "resistor_ladder_key_decoder_assert.svh"

    t_cfg                 w_cfg;
    t_in_item             r_s1;
    logic                 r_s1_valid;
    t_out_item            r_out;
    logic                 r_out_valid;
    logic [HELD_BITS-1:0] r_prev_mask;
    t_pwr_state           r_pwr;
    t_out_item            n_out;
    t_pwr_state           n_pwr;
    logic                 w_adv;
    logic                 w_take;

    rlkd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rlkd_decode u_decode (
        .i_cfg       (w_cfg),
        .i_item      (r_s1),
        .i_prev_mask (r_prev_mask),
        .i_pwr       (r_pwr),
        .o_res       (n_out),
        .o_pwr       (n_pwr)
    );

    assign w_adv       = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || w_adv;
    assign w_take      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev_mask <= '0;
            r_pwr       <= '0;
        end else begin
            if (w_take) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_prev_mask <= n_out.held_keys;
                r_pwr       <= n_pwr;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1 <= i_in_item;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    `RLKD_ASSERT_IMP(a_key_is_held, r_out_valid && (r_out.new_key != KEY_NONE),
        r_out.held_keys[r_out.new_key - 3'd1], "reported key not in held mask")
    `RLKD_ASSERT_IMP(a_long_needs_power, r_out_valid && r_out.power_long_held,
        r_out.held_keys[POWER_BIT], "long hold flagged without power held")
    `RLKD_ASSERT_IMP(a_prev_mask_tracks, r_out_valid,
        r_prev_mask == r_out.held_keys, "stored mask differs from last result")
    `RLKD_ASSERT_IMP(a_pwr_tracks, r_out_valid,
        r_pwr.active == r_out.held_keys[POWER_BIT], "power timer out of step")
    `RLKD_ASSERT_NXT(a_stall_keeps_state, r_out_valid && !i_out_ready,
        r_prev_mask == $past(r_prev_mask), "key state moved during output stall")

endmodule

@@ verif/key_decode_checker.sv @@
// Checker for the ladder key decoder: follows config writes, predicts each poll, compares
`timescale 1ns / 1ps

module key_decode_checker import rlkd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_item             i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_item            i_out_item,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic                 i_pready,
    input  logic [ADDR_BITS-1:0] i_paddr,
    input  logic [DATA_BITS-1:0] i_pwdata,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam logic [SAMPLE_BITS-1:0] DEF_L1_TOP     = 12'd3900;
    localparam logic [SAMPLE_BITS-1:0] DEF_L1_BACK    = 12'd3100;
    localparam logic [SAMPLE_BITS-1:0] DEF_L1_CONFIRM = 12'd2090;
    localparam logic [SAMPLE_BITS-1:0] DEF_L1_LEFT    = 12'd750;
    localparam logic [SAMPLE_BITS-1:0] DEF_L2_TOP     = 12'd3900;
    localparam logic [SAMPLE_BITS-1:0] DEF_L2_UP      = 12'd1120;

    localparam int BACK_BIT    = 0;
    localparam int CONFIRM_BIT = 1;
    localparam int LEFT_BIT    = 2;
    localparam int RIGHT_BIT   = 3;
    localparam int UP_BIT      = 4;
    localparam int DOWN_BIT    = 5;

    logic [SAMPLE_BITS-1:0] l1_top, l1_back, l1_confirm, l1_left, l2_top, l2_up;
    logic [TIME_BITS-1:0]   hold_ms;
    logic [HELD_BITS-1:0]   prev_held;
    logic                   pwr_timing;
    logic [TIME_BITS-1:0]   pwr_start;
    t_out_item              expected_reports[$];

    task automatic decode_poll(input t_in_item p, output t_out_item r);
        logic [HELD_BITS-1:0]   held;
        logic [HELD_BITS-1:0]   fresh;
        logic [SAMPLE_BITS-1:0] v1;
        logic [SAMPLE_BITS-1:0] v2;
        logic [TIME_BITS-1:0]   elapsed;
        logic [KEY_BITS-1:0]    code;
        int                     k;
        held = '0;
        v1 = p.ladder1_sample;
        v2 = p.ladder2_sample;
        // first matching bucket wins, bounds may be unordered
        if (v1 <= l1_top && v1 > l1_back) begin
            held[BACK_BIT] = 1'b1;
        end else if (v1 <= l1_back && v1 > l1_confirm) begin
            held[CONFIRM_BIT] = 1'b1;
        end else if (v1 <= l1_confirm && v1 > l1_left) begin
            held[LEFT_BIT] = 1'b1;
        end else if (v1 <= l1_left) begin
            held[RIGHT_BIT] = 1'b1;
        end
        if (v2 <= l2_top && v2 > l2_up) begin
            held[UP_BIT] = 1'b1;
        end else if (v2 <= l2_up) begin
            held[DOWN_BIT] = 1'b1;
        end
        held[POWER_BIT] = p.power_pressed;
        fresh = held & ~prev_held;
        prev_held = held;
        if (p.power_pressed) begin
            if (!pwr_timing) begin
                pwr_timing = 1'b1;
                pwr_start = p.now_ms;
            end
        end else begin
            pwr_timing = 1'b0;
            pwr_start = '0;
        end
        elapsed = p.now_ms - pwr_start;
        code = KEY_NONE;
        for (k = HELD_BITS - 1; k >= 0; k--) begin
            if (fresh[k]) code = KEY_BITS'(k + 1);
        end
        r.new_key = code;
        r.held_keys = held;
        r.power_long_held = pwr_timing && (elapsed >= hold_ms);
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            l1_top = DEF_L1_TOP;
            l1_back = DEF_L1_BACK;
            l1_confirm = DEF_L1_CONFIRM;
            l1_left = DEF_L1_LEFT;
            l2_top = DEF_L2_TOP;
            l2_up = DEF_L2_UP;
            hold_ms = '0;
            prev_held = '0;
            pwr_timing = 1'b0;
            pwr_start = '0;
            expected_reports.delete();
            o_pending = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[ADDR_BITS-1:2]))
                    REG_L1_TOP:     l1_top = i_pwdata[SAMPLE_BITS-1:0];
                    REG_L1_BACK:    l1_back = i_pwdata[SAMPLE_BITS-1:0];
                    REG_L1_CONFIRM: l1_confirm = i_pwdata[SAMPLE_BITS-1:0];
                    REG_L1_LEFT:    l1_left = i_pwdata[SAMPLE_BITS-1:0];
                    REG_L2_TOP:     l2_top = i_pwdata[SAMPLE_BITS-1:0];
                    REG_L2_UP:      l2_up = i_pwdata[SAMPLE_BITS-1:0];
                    REG_HOLD_MS:    hold_ms = i_pwdata[TIME_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result item with none expected");
                    o_fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (i_out_item.new_key !== want.new_key) begin
                        $error("new_key: expected %0d, got %0d",
                               want.new_key, i_out_item.new_key);
                        o_fail_count++;
                    end
                    if (i_out_item.held_keys !== want.held_keys) begin
                        $error("held_keys: expected %b, got %b",
                               want.held_keys, i_out_item.held_keys);
                        o_fail_count++;
                    end
                    if (i_out_item.power_long_held !== want.power_long_held) begin
                        $error("power_long_held: expected %b, got %b",
                               want.power_long_held, i_out_item.power_long_held);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_poll(i_in_item, want);
                expected_reports.push_back(want);
            end
            o_pending = expected_reports.size();
        end
    end

endmodule

@@ verif/tb_resistor_ladder_key_decoder.sv @@
// Testbench top for the ladder key decoder: clock, reset, stimulus, config and verdict
`timescale 1ns / 1ps

module tb_resistor_ladder_key_decoder;
    import rlkd_pkg::*;

    localparam int LIMIT_CYCLES     = 500000;
    localparam int PHASE_ITEMS      = 225;
    localparam int PHASES           = 8;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int MAX_WAIT         = 16;
    localparam logic [IDX_BITS-1:0] REG_UNUSED = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_item             in_item;
    logic                 out_valid;
    logic                 out_ready;
    t_out_item            out_item;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    int                   fail_count;
    int                   pending;

    int                   tx_max;
    int                   rx_max;
    bit                   hold_req;

    logic [SAMPLE_BITS-1:0] cur_l1_top, cur_l1_back, cur_l1_confirm, cur_l1_left;
    logic [SAMPLE_BITS-1:0] cur_l2_top, cur_l2_up;
    logic [TIME_BITS-1:0]   cur_hold;
    logic [TIME_BITS-1:0]   pwr_since;
    t_in_item               last_poll;

    resistor_ladder_key_decoder DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    key_decode_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin : watchdog
        int cycles;
        for (cycles = 0; cycles < LIMIT_CYCLES; cycles++) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    // result side: random stall per item, plus one long hold-off on request
    initial begin : result_sink
        int wait_cyc;
        int hold_left;
        bit hold_done;
        out_ready = 1'b0;
        wait_cyc = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (wait_cyc > 0) begin
                wait_cyc--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
            @(posedge clk);
            if (rst_n && out_valid && out_ready) wait_cyc = $urandom_range(0, rx_max);
        end
    end

    function automatic t_in_item mk_poll(input logic [SAMPLE_BITS-1:0] s1,
                                         input logic [SAMPLE_BITS-1:0] s2,
                                         input logic pwr,
                                         input logic [TIME_BITS-1:0] now);
        t_in_item p;
        p.ladder1_sample = s1;
        p.ladder2_sample = s2;
        p.power_pressed = pwr;
        p.now_ms = now;
        return p;
    endfunction

    // mostly near a bound, sometimes the rails or anywhere
    function automatic logic [SAMPLE_BITS-1:0] pick_level(input logic [SAMPLE_BITS-1:0] a,
                                                          input logic [SAMPLE_BITS-1:0] b,
                                                          input logic [SAMPLE_BITS-1:0] c,
                                                          input logic [SAMPLE_BITS-1:0] d);
        logic [SAMPLE_BITS-1:0] base;
        case ($urandom_range(0, 9))
            0, 1: return SAMPLE_BITS'($urandom);
            2: return '0;
            3: return '1;
            default: begin
                case ($urandom_range(0, 3))
                    0: base = a;
                    1: base = b;
                    2: base = c;
                    default: base = d;
                endcase
                return base + SAMPLE_BITS'($urandom_range(0, 2)) - 12'd1;
            end
        endcase
    endfunction

    task automatic send_poll(input t_in_item p);
        int gap;
        gap = $urandom_range(0, tx_max);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= p;
        last_poll = p;
        forever begin
            @(posedge clk);
            if (in_ready) break;
        end
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [DATA_BITS-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [SAMPLE_BITS-1:0] t1, input logic [SAMPLE_BITS-1:0] b1,
                              input logic [SAMPLE_BITS-1:0] c1, input logic [SAMPLE_BITS-1:0] f1,
                              input logic [SAMPLE_BITS-1:0] t2, input logic [SAMPLE_BITS-1:0] u2,
                              input logic [TIME_BITS-1:0] hold);
        // junk above the 12-bit bounds must be dropped
        write_reg(REG_L1_TOP, {20'($urandom), t1});
        write_reg(REG_L1_BACK, {20'($urandom), b1});
        write_reg(REG_L1_CONFIRM, {20'($urandom), c1});
        write_reg(REG_L1_LEFT, {20'($urandom), f1});
        write_reg(REG_L2_TOP, {20'($urandom), t2});
        write_reg(REG_L2_UP, {20'($urandom), u2});
        write_reg(REG_HOLD_MS, hold);
        cur_l1_top = t1;
        cur_l1_back = b1;
        cur_l1_confirm = c1;
        cur_l1_left = f1;
        cur_l2_top = t2;
        cur_l2_up = u2;
        cur_hold = hold;
    endtask

    // keys tend to stay held over several polls; time mostly runs forward
    task automatic make_poll(output t_in_item p);
        p = last_poll;
        if ($urandom_range(0, 9) < 4)
            p.ladder1_sample = pick_level(cur_l1_top, cur_l1_back, cur_l1_confirm, cur_l1_left);
        if ($urandom_range(0, 9) < 4)
            p.ladder2_sample = pick_level(cur_l2_top, cur_l2_up, cur_l2_top, cur_l2_up);
        if ($urandom_range(0, 9) < 2) p.power_pressed = ~p.power_pressed;
        case ($urandom_range(0, 9))
            0: p.now_ms = $urandom;
            1: p.now_ms = pwr_since + cur_hold;
            2: p.now_ms = pwr_since + cur_hold - 32'd1;
            3: p.now_ms = 32'hFFFF_FFF8 + TIME_BITS'($urandom_range(0, 15));
            default: p.now_ms = last_poll.now_ms + TIME_BITS'($urandom_range(0, 8));
        endcase
        if (p.power_pressed && !last_poll.power_pressed) pwr_since = p.now_ms;
    endtask

    initial begin : stimulus
        int ph;
        t_in_item it;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 1'b0;
        tx_max = 3;
        rx_max = 3;
        last_poll = '0;
        pwr_since = '0;
        cur_l1_top = 12'd3900;
        cur_l1_back = 12'd3100;
        cur_l1_confirm = 12'd2090;
        cur_l1_left = 12'd750;
        cur_l2_top = 12'd3900;
        cur_l2_up = 12'd1120;
        cur_hold = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default bounds, bucket edges, power hold from time zero with zero hold time
        send_poll(mk_poll(12'd4095, 12'd4095, 1'b0, 32'd0));
        send_poll(mk_poll(12'd3900, 12'd4095, 1'b1, 32'd0));
        send_poll(mk_poll(12'd3901, 12'd3900, 1'b1, 32'd5));
        send_poll(mk_poll(12'd3100, 12'd1120, 1'b1, 32'hFFFF_FFFF));
        send_poll(mk_poll(12'd3101, 12'd1121, 1'b0, 32'd7));
        send_poll(mk_poll(12'd2090, 12'd0, 1'b0, 32'd8));
        send_poll(mk_poll(12'd2091, 12'd3901, 1'b1, 32'd9));
        send_poll(mk_poll(12'd750, 12'd4095, 1'b1, 32'd10));
        send_poll(mk_poll(12'd751, 12'd0, 1'b0, 32'd11));
        send_poll(mk_poll(12'd0, 12'd4095, 1'b0, 32'd12));
        send_poll(mk_poll(12'd4095, 12'd4095, 1'b0, 32'd13));
        // three keys new at once
        send_poll(mk_poll(12'd3900, 12'd3900, 1'b1, 32'd14));
        send_poll(mk_poll(12'd3900, 12'd3900, 1'b1, 32'd15));

        // unordered bounds, hold timing across the time wrap, ignored register index
        set_config(12'd100, 12'd2000, 12'd50, 12'd3000, 12'd200, 12'd1000, 32'd10);
        write_reg(REG_UNUSED, $urandom);
        send_poll(mk_poll(12'd50, 12'd4095, 1'b0, 32'd0));
        send_poll(mk_poll(12'd101, 12'd150, 1'b1, 32'hFFFF_FFFA));
        send_poll(mk_poll(12'd2500, 12'd1500, 1'b1, 32'hFFFF_FFFF));
        send_poll(mk_poll(12'd3500, 12'd1000, 1'b1, 32'd3));
        send_poll(mk_poll(12'd4095, 12'd0, 1'b1, 32'd4));
        send_poll(mk_poll(12'd2001, 12'd201, 1'b0, 32'd5));
        send_poll(mk_poll(12'd3000, 12'd4095, 1'b0, 32'd6));

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_config('1, '1, '1, '1, '1, '1, '1);
                1: set_config('0, '0, '0, '0, '0, '0, '0);
                2: set_config(12'd3900, 12'd3100, 12'd2090, 12'd750, 12'd3900, 12'd1120,
                              32'd25);
                default: begin
                    if ($urandom_range(0, 1) == 0) begin
                        it.ladder1_sample = SAMPLE_BITS'($urandom_range(0, 4095));
                        it.ladder2_sample = SAMPLE_BITS'($urandom_range(0, 4095));
                        set_config(it.ladder1_sample,
                                   SAMPLE_BITS'($urandom_range(0, it.ladder1_sample)),
                                   SAMPLE_BITS'($urandom_range(0, it.ladder1_sample / 2)),
                                   SAMPLE_BITS'($urandom_range(0, it.ladder1_sample / 4)),
                                   it.ladder2_sample,
                                   SAMPLE_BITS'($urandom_range(0, it.ladder2_sample)),
                                   $urandom_range(0, 40));
                    end else begin
                        set_config(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                                   SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                                   SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                                   ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40));
                    end
                end
            endcase
            case (ph % 3)
                0: begin
                    tx_max = MAX_WAIT;
                    rx_max = MAX_WAIT;
                end
                1: begin
                    tx_max = 0;
                    rx_max = 0;
                end
                default: begin
                    tx_max = $urandom_range(0, MAX_WAIT);
                    rx_max = $urandom_range(0, MAX_WAIT);
                end
            endcase
            // back-pressure: result side stops while polls keep coming
            if (ph == 4) hold_req = 1'b1;
            repeat (PHASE_ITEMS) begin
                make_poll(it);
                send_poll(it);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
